>>> design/assert_macros.svh
// Assertion macros used by the checker file ssdb_chk.sv.
// Needs signals clk and rst in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSDB_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ssdb_pkg.sv
// Types, constants and the arctangent step table for the shot distance pipeline.
// No dependencies.
package ssdb_pkg;

  localparam int TABLE_LEN = 40;
  localparam logic signed [15:0] RIGHT_ANGLE = 16'sd23040;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic        east;
    logic        north;
    logic        up;
  } diff_t;

  typedef struct packed {
    logic [33:0] h;
    logic [33:0] s;
    logic        degen;
  } dist_t;

  typedef struct packed {
    logic [65:0] rem;
    logic [33:0] r;
  } root_t;

  typedef struct packed {
    logic signed [61:0] x;
    logic signed [61:0] y;
    logic [58:0]        big;
    logic signed [25:0] z;
    logic               xzero;
    logic               yzero;
    logic               yneg;
  } lane_t;

  function automatic logic signed [25:0] angle_step(input int i);
    logic signed [25:0] v;
    case (i)
      0: v = 26'sd2949120;   1: v = 26'sd1740967;   2: v = 26'sd919879;
      3: v = 26'sd466945;    4: v = 26'sd234379;    5: v = 26'sd117304;
      6: v = 26'sd58666;     7: v = 26'sd29335;     8: v = 26'sd14668;
      9: v = 26'sd7334;      10: v = 26'sd3667;     11: v = 26'sd1833;
      12: v = 26'sd917;      13: v = 26'sd458;      14: v = 26'sd229;
      15: v = 26'sd115;      16: v = 26'sd57;       17: v = 26'sd29;
      18: v = 26'sd14;       19: v = 26'sd7;        20: v = 26'sd4;
      21: v = 26'sd2;        22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  // One restoring square root digit at bit b.
  function automatic root_t root_step(input root_t p, input int b);
    root_t       o;
    logic [69:0] t;
    o = p;
    t = (70'(p.r) << (b + 1)) + (70'(1) << (2 * b));
    if (70'(p.rem) >= t) begin
      o.rem = 66'(70'(p.rem) - t);
      o.r   = p.r | (34'(1) << b);
    end
    return o;
  endfunction

endpackage

>>> design/survey_shot_distance_bearing.sv
// Distance and bearing between two survey stations, fully pipelined.
// Depends on ssdb_pkg.
//
// One station pair is taken every cycle while in_stall is low; the pipeline has
// 47 + min(CORDIC_STAGES, 40) register stages: the 34 digit stages of the square
// roots, six normalising shift stages, one stage per CORDIC iteration and seven
// stages of setup and rounding. A stall on the result side holds the whole pipeline,
// and is passed back on in_stall in the same cycle.
module survey_shot_distance_bearing #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] from_x,
  input  logic signed [31:0] from_y,
  input  logic signed [31:0] from_z,
  input  logic signed [31:0] to_x,
  input  logic signed [31:0] to_y,
  input  logic signed [31:0] to_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        east_abs,
  output logic               is_east,
  output logic [31:0]        north_abs,
  output logic               is_north,
  output logic [31:0]        vertical_abs,
  output logic               is_up,
  output logic [32:0]        horiz_dist,
  output logic [32:0]        slope_dist,
  output logic signed [15:0] incline_deg,
  output logic signed [15:0] bearing_deg,
  output logic               degenerate
);
  import ssdb_pkg::*;

  localparam int NC    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int DEPTH = 47 + NC;
  localparam int ND    = DEPTH - 38;
  localparam int NL    = 7 + NC;

  logic              en;
  logic [DEPTH-1:0]  v;
  diff_t             base [DEPTH];
  dist_t             dstg [ND];
  logic [63:0]       sq [3];
  logic [64:0]       sumh2;
  logic [63:0]       az2;
  logic [64:0]       sumh3;
  logic [65:0]       sums3;
  root_t             rh [34];
  root_t             rs [34];
  lane_t             ln [2][NL];
  logic signed [15:0] ang [2];
  logic signed [32:0] dx, dy, dz;
  diff_t             d0;

  assign en        = !(v[DEPTH-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = v[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DEPTH-2:0], in_valid};
    end
  end

  always_comb begin
    dx = 33'(to_x) - 33'(from_x);
    dy = 33'(to_y) - 33'(from_y);
    dz = 33'(to_z) - 33'(from_z);
    d0.ax    = dx[32] ? 32'(-dx) : dx[31:0];
    d0.ay    = dy[32] ? 32'(-dy) : dy[31:0];
    d0.az    = dz[32] ? 32'(-dz) : dz[31:0];
    d0.east  = !dx[32] && (dx != '0);
    d0.north = !dy[32] && (dy != '0);
    d0.up    = !dz[32] && (dz != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base[0] <= d0;
      for (int k = 1; k < DEPTH; k++) begin
        base[k] <= base[k-1];
      end
      sq[0] <= base[0].ax * base[0].ax;
      sq[1] <= base[0].ay * base[0].ay;
      sq[2] <= base[0].az * base[0].az;
      sumh2 <= 65'(sq[0]) + 65'(sq[1]);
      az2   <= sq[2];
      sumh3 <= sumh2;
      sums3 <= 66'(sumh2) + 66'(az2);
      rh[0] <= root_step(root_t'{rem: 66'(sumh3), r: '0}, 33);
      rs[0] <= root_step(root_t'{rem: sums3, r: '0}, 33);
      for (int j = 1; j < 34; j++) begin
        rh[j] <= root_step(rh[j-1], 33 - j);
        rs[j] <= root_step(rs[j-1], 33 - j);
      end
      dstg[0].h     <= rh[33].r + 34'(rh[33].rem > 66'(rh[33].r));
      dstg[0].s     <= rs[33].r + 34'(rs[33].rem > 66'(rs[33].r));
      dstg[0].degen <= (rh[33].r == '0) && (rh[33].rem == '0);
      for (int m = 1; m < ND; m++) begin
        dstg[m] <= dstg[m-1];
      end
    end
  end

  // Prepare both arctangent lanes: bearing is dx over |dy|, incline dz over horiz.
  always_ff @(posedge clk) begin
    if (en) begin
      ln[0][0].x     <= 62'(base[38].ay);
      ln[0][0].y     <= 62'(base[38].ax);
      ln[0][0].big   <= 59'((base[38].ay > base[38].ax) ? base[38].ay : base[38].ax);
      ln[0][0].z     <= '0;
      ln[0][0].xzero <= (base[38].ay == '0);
      ln[0][0].yzero <= (base[38].ax == '0);
      ln[0][0].yneg  <= (base[38].ax != '0) && !base[38].east;
      ln[1][0].x     <= 62'(dstg[0].h);
      ln[1][0].y     <= 62'(base[38].az);
      ln[1][0].big   <= 59'((dstg[0].h > 34'(base[38].az)) ? dstg[0].h
                                                           : 34'(base[38].az));
      ln[1][0].z     <= '0;
      ln[1][0].xzero <= (dstg[0].h == '0);
      ln[1][0].yzero <= (base[38].az == '0);
      ln[1][0].yneg  <= (base[38].az != '0) && !base[38].up;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar n = 0; n < 6; n++) begin : g_norm
      localparam int K = 32 >> n;
      lane_t nx;
      always_comb begin
        nx = ln[l][n];
        if (ln[l][n].big[58 -: K] == '0) begin
          nx.big = ln[l][n].big << K;
          nx.x   = ln[l][n].x << K;
          nx.y   = ln[l][n].y << K;
        end
        if (n == 5 && nx.yneg) begin
          nx.y = -nx.y;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          ln[l][n+1] <= nx;
        end
      end
    end

    for (genvar i = 0; i < NC; i++) begin : g_cordic
      lane_t p, cx;
      assign p = ln[l][6+i];
      always_comb begin
        cx = p;
        if (p.y >= 0) begin
          cx.x = p.x + (p.y >>> i);
          cx.y = p.y - (p.x >>> i);
          cx.z = p.z + angle_step(i);
        end else begin
          cx.x = p.x - (p.y >>> i);
          cx.y = p.y + (p.x >>> i);
          cx.z = p.z - angle_step(i);
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          ln[l][7+i] <= cx;
        end
      end
    end

    lane_t              f;
    logic signed [26:0] zr;
    logic signed [18:0] res;
    logic signed [15:0] a;
    assign f = ln[l][NL-1];
    always_comb begin
      zr  = 27'(f.z) + 27'sd128;
      res = 19'(zr >>> 8);
      if (res > 19'(RIGHT_ANGLE)) begin
        a = RIGHT_ANGLE;
      end else if (res < -19'(RIGHT_ANGLE)) begin
        a = -RIGHT_ANGLE;
      end else begin
        a = res[15:0];
      end
      if (f.yzero || dstg[ND-2].degen) begin
        a = '0;
      end else if (f.xzero) begin
        a = f.yneg ? -RIGHT_ANGLE : RIGHT_ANGLE;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ang[l] <= a;
      end
    end
  end

  assign east_abs     = base[DEPTH-1].ax;
  assign is_east      = base[DEPTH-1].east;
  assign north_abs    = base[DEPTH-1].ay;
  assign is_north     = base[DEPTH-1].north;
  assign vertical_abs = base[DEPTH-1].az;
  assign is_up        = base[DEPTH-1].up;
  assign horiz_dist   = dstg[ND-1].h[32:0];
  assign slope_dist   = dstg[ND-1].s[32:0];
  assign degenerate   = dstg[ND-1].degen;
  assign bearing_deg  = ang[0];
  assign incline_deg  = ang[1];

endmodule

>>> design/ssdb_chk.sv
// Port checker for the shot distance pipeline, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module ssdb_chk (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [32:0]        horiz_dist,
  input logic [32:0]        slope_dist,
  input logic signed [15:0] incline_deg,
  input logic signed [15:0] bearing_deg,
  input logic               degenerate
);
  `SSDB_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid, "request dropped under stall")
  `SSDB_ASSERT(a_degen, out_valid && degenerate, incline_deg == 0 && bearing_deg == 0, "angles not zeroed")
  `SSDB_ASSERT(a_flag, out_valid && horiz_dist == 0, degenerate, "zero distance not flagged")
  `SSDB_ASSERT(a_order, out_valid, slope_dist >= horiz_dist, "slope below horizontal")
endmodule

bind survey_shot_distance_bearing ssdb_chk u_chk (.*);
